/* rtl/page_region_allocator_macros.svh */
// Assertion helpers for the region allocator
`ifndef PAGE_REGION_ALLOCATOR_MACROS_SVH
`define PAGE_REGION_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define PRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pra_pkg.sv */
// ----------------------------------------------------------------------------
// pra_pkg
// Types and codes shared by the region allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pra_pkg;

    // index field width, covers up to 256 table entries
    localparam int IDX_BITS = 8;

    localparam logic [2:0] OP_MAP   = 3'd0;
    localparam logic [2:0] OP_UNMAP = 3'd1;
    localparam logic [2:0] OP_BRK   = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOSPC = 2'd2;

    localparam logic [2:0] REG_HEAP_FLOOR  = 3'd0;
    localparam logic [2:0] REG_WINDOW_BASE = 3'd1;
    localparam logic [2:0] REG_WINDOW_TOP  = 3'd2;
    localparam logic [2:0] REG_HEAP_START  = 3'd3;
    localparam logic [2:0] REG_HEAP_LIMIT  = 3'd4;

    // query travelling down the cell chain
    typedef struct packed {
        logic                active;
        logic                unmap;
        logic [31:0]         base;
        logic [31:0]         len;
        logic                hit;
        logic [31:0]         lo;
        logic                free_found;
        logic [IDX_BITS-1:0] free_idx;
    } query_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic                clr_all;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_idx;
        logic [31:0]         wr_base;
        logic [31:0]         wr_len;
    } tbl_ctl_t;

endpackage

/* rtl/pra_cell.sv */
// ----------------------------------------------------------------------------
// pra_cell
// One mapping entry; checks the passing query and hands it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_cell
    import pra_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_ctl_t ctl,
    input  query_t   q_in,
    output query_t   q_out
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] base_reg;
    logic [31:0] len_reg;
    query_t      q_reg;
    query_t      q_next;
    logic        meet;
    logic        match;
    logic        sel;

    assign sel   = (ctl.wr_idx == IDX_BITS'(IDX));
    assign meet  = ({1'b0, q_in.base} < ({1'b0, base_reg} + {1'b0, len_reg}))
                && ({1'b0, base_reg} < ({1'b0, q_in.base} + {1'b0, q_in.len}));
    assign match = (base_reg == q_in.base) && (len_reg == q_in.len);

    always_comb
    begin
        q_next     = q_in;
        valid_next = valid_reg;
        if (q_in.active)
        begin
            if (q_in.unmap)
            begin
                // first exact match frees itself
                if (valid_reg && match && !q_in.hit)
                begin
                    q_next.hit = 1'b1;
                    valid_next = 1'b0;
                end
            end
            else
            begin
                if (valid_reg && meet && !q_in.hit)
                begin
                    q_next.hit = 1'b1;
                    q_next.lo  = base_reg;
                end
                if (!valid_reg && !q_in.free_found)
                begin
                    q_next.free_found = 1'b1;
                    q_next.free_idx   = IDX_BITS'(IDX);
                end
            end
        end
        if (ctl.clr_all)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.wr_en && sel)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            q_reg     <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && sel)
        begin
            base_reg <= ctl.wr_base;
            len_reg  <= ctl.wr_len;
        end
    end

    assign q_out = q_reg;

endmodule

/* rtl/page_region_allocator.sv */
// ----------------------------------------------------------------------------
// page_region_allocator
// Mapping table and heap break of one task, placed by first-fit top-down search.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are taken when start is high and busy is low. The result appears
//   on status/value for one cycle with done high; the receiver cannot stall.
//   Registers are written on the cfg channel (cfg_ready always high); indices
//   above 4 are ignored. The user must write them only while the block is idle;
//   the block itself does not enforce this.
// Operation:
//   Start, end task, argument errors and a break that does not grow need no chain pass.
//   Unmap and break growth: one pass down the cell chain.
//   Map: one chain pass per candidate tried; each blocked candidate jumps below the
//   range it hit, so the passes are bounded by the mappings and heap met on the way down.
//   The chain of table cells, one per entry, sets the pass length.
//   One command at a time.
// Reset:
//   Table empty, break zero, task stopped, registers at their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_region_allocator
    import pra_pkg::*;
#(
    parameter int MAX_MAPPINGS = 16,
    parameter int PAGE_BYTES   = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [31:0] address,
    input  logic [31:0] length,
    input  logic        fixed_place,
    input  logic        sharing_given,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "page_region_allocator_macros.svh"

    localparam logic [31:0] PMASK = 32'(PAGE_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] heap_floor_reg, window_base_reg, window_top_reg;
    logic [31:0] heap_start_reg, heap_limit_reg;
    logic [31:0] heap_break_reg, heap_break_next;
    logic        running_reg, running_next;
    logic [2:0]  op_reg, op_next;
    logic        fixed_reg, fixed_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] cand_reg, cand_next;
    logic [31:0] req_reg, req_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] value_reg, value_next;
    query_t      launch_reg, launch_next;
    tbl_ctl_t    ctl_reg, ctl_next;
    query_t      chain [MAX_MAPPINGS+1];
    query_t      ret;
    logic [31:0] in_size;
    logic        accept;
    logic        heap_meet;
    logic        any_hit;
    logic [31:0] lo;
    logic [32:0] need;
    logic [33:0] step;

    assign chain[0]  = launch_reg;
    assign ret       = chain[MAX_MAPPINGS];
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign status    = status_reg;
    assign value     = value_reg;
    assign accept    = start && !busy;
    assign in_size   = (length + PMASK) & ~PMASK;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_MAPPINGS; gi++)
        begin : g_cell
            pra_cell #(.IDX(gi)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl_reg),
                .q_in  (chain[gi]),
                .q_out (chain[gi+1])
            );
        end
    endgenerate

    // heap is [heap floor, heap_break)
    assign heap_meet = (heap_break_reg > heap_floor_reg) && (cand_reg < heap_break_reg)
                    && ({1'b0, heap_floor_reg} < ({1'b0, cand_reg} + {1'b0, size_reg}));
    assign any_hit   = ret.hit || heap_meet;
    assign lo        = ret.hit ? ret.lo : heap_floor_reg;
    assign need      = {1'b0, cand_reg} + {1'b0, size_reg} - {1'b0, lo};
    assign step      = ({1'b0, need} + {2'b00, PMASK}) & ~{2'b00, PMASK};

    always_comb
    begin
        state_next      = state_reg;
        heap_break_next = heap_break_reg;
        running_next    = running_reg;
        op_next         = op_reg;
        fixed_next      = fixed_reg;
        size_next       = size_reg;
        cand_next       = cand_reg;
        req_next        = req_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        launch_next     = launch_reg;
        launch_next.active = 1'b0;
        ctl_next        = ctl_reg;
        ctl_next.clr_all = 1'b0;
        ctl_next.wr_en   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = operation;
                    fixed_next  = fixed_place;
                    size_next   = in_size;
                    req_next    = address;
                    status_next = ST_OK;
                    value_next  = '0;
                    state_next  = S_DONE;
                    launch_next.unmap      = 1'b0;
                    launch_next.hit        = 1'b0;
                    launch_next.lo         = '0;
                    launch_next.free_found = 1'b0;
                    launch_next.free_idx   = '0;
                    case (operation)
                        OP_MAP:
                        begin
                            if ((in_size == '0) || !sharing_given)
                            begin
                                status_next = ST_INVAL;
                            end
                            else
                            begin
                                cand_next = fixed_place ? (address & ~PMASK)
                                                        : (window_top_reg - in_size);
                                launch_next.active = 1'b1;
                                launch_next.base   = cand_next;
                                launch_next.len    = in_size;
                                state_next         = S_WAIT;
                            end
                        end
                        OP_UNMAP:
                        begin
                            launch_next.active = 1'b1;
                            launch_next.unmap  = 1'b1;
                            launch_next.base   = address;
                            launch_next.len    = in_size;
                            state_next         = S_WAIT;
                        end
                        OP_BRK:
                        begin
                            if (!running_reg && (heap_break_reg == '0))
                            begin
                                value_next = '0;
                            end
                            else if ((address == '0) || (address < heap_start_reg)
                                     || (address >= heap_limit_reg))
                            begin
                                value_next = heap_break_reg;
                            end
                            else if (address > heap_break_reg)
                            begin
                                // growth: new pages must not meet a mapping
                                launch_next.active = 1'b1;
                                launch_next.base   = heap_break_reg;
                                launch_next.len    = address - heap_break_reg;
                                state_next         = S_WAIT;
                            end
                            else
                            begin
                                heap_break_next = address;
                                value_next      = address;
                            end
                        end
                        OP_START:
                        begin
                            ctl_next.clr_all = 1'b1;
                            heap_break_next  = heap_start_reg;
                            running_next     = 1'b1;
                            value_next       = heap_start_reg;
                        end
                        OP_END:
                        begin
                            running_next = 1'b0;
                            value_next   = heap_break_reg;
                        end
                        default:
                        begin
                            status_next = ST_INVAL;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (ret.active)
                begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_MAP:
                        begin
                            if (!ret.free_found)
                            begin
                                status_next = ST_NOSPC;
                            end
                            else if (fixed_reg)
                            begin
                                if ((cand_reg < window_base_reg)
                                    || (({1'b0, cand_reg} + {1'b0, size_reg})
                                        > {1'b0, window_top_reg})
                                    || any_hit)
                                begin
                                    status_next = ST_INVAL;
                                end
                                else
                                begin
                                    ctl_next.wr_en   = 1'b1;
                                    ctl_next.wr_idx  = ret.free_idx;
                                    ctl_next.wr_base = cand_reg;
                                    ctl_next.wr_len  = size_reg;
                                    value_next       = cand_reg;
                                end
                            end
                            else if ((size_reg > window_top_reg)
                                     || (cand_reg < window_base_reg))
                            begin
                                status_next = ST_NOSPC;
                            end
                            else if (any_hit)
                            begin
                                if (step > {2'b00, cand_reg})
                                begin
                                    status_next = ST_NOSPC;
                                end
                                else
                                begin
                                    // next candidate ends at or below the range hit
                                    cand_next          = cand_reg - step[31:0];
                                    launch_next.active = 1'b1;
                                    launch_next.base   = cand_next;
                                    state_next         = S_WAIT;
                                end
                            end
                            else
                            begin
                                ctl_next.wr_en   = 1'b1;
                                ctl_next.wr_idx  = ret.free_idx;
                                ctl_next.wr_base = cand_reg;
                                ctl_next.wr_len  = size_reg;
                                value_next       = cand_reg;
                            end
                        end
                        OP_UNMAP:
                        begin
                            status_next = ret.hit ? ST_OK : ST_INVAL;
                        end
                        OP_BRK:
                        begin
                            if (ret.hit)
                            begin
                                value_next = heap_break_reg;
                            end
                            else
                            begin
                                heap_break_next = req_reg;
                                value_next      = req_reg;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVAL;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            heap_break_reg    <= '0;
            running_reg       <= 1'b0;
            launch_reg        <= '0;
            ctl_reg           <= '0;
            heap_floor_reg    <= 32'd4194304;
            window_base_reg   <= 32'd536870912;
            window_top_reg    <= 32'd805306368;
            heap_start_reg    <= 32'd4194304;
            heap_limit_reg    <= 32'd536870912;
        end
        else
        begin
            state_reg         <= state_next;
            heap_break_reg    <= heap_break_next;
            running_reg       <= running_next;
            launch_reg        <= launch_next;
            ctl_reg           <= ctl_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HEAP_FLOOR:  heap_floor_reg  <= cfg_data;
                    REG_WINDOW_BASE: window_base_reg <= cfg_data;
                    REG_WINDOW_TOP:  window_top_reg  <= cfg_data;
                    REG_HEAP_START:  heap_start_reg  <= cfg_data;
                    REG_HEAP_LIMIT:  heap_limit_reg  <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        fixed_reg   <= fixed_next;
        size_reg    <= size_next;
        cand_reg    <= cand_next;
        req_reg     <= req_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
    end

    `PRA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
    `PRA_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")
    `PRA_ASSERT_NOW(a_status_code, done, status != 2'd3, "undefined status code")
    `PRA_ASSERT_NOW(a_no_launch_idle, launch_reg.active, state_reg == S_WAIT,
                    "chain query launched outside a wait")

endmodule

/* sim/tb_page_region_allocator.sv */
// ----------------------------------------------------------------------------
// tb_page_region_allocator
// Self-checking bench for the mapping table and heap break allocator.
// Commands are driven through the start/busy handshake. Each accepted command
// is run through a local copy of the table and break, and the expected
// outcome is queued. Every done strobe is compared against the queue head.
// Directed tests cover the corner cases. Random phases then run under
// several window and heap settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_page_region_allocator;
    import pra_pkg::*;

    localparam int MAPS    = 16;
    localparam int PAGE_SZ = 4096;
    localparam logic [31:0] PMASK = 32'(PAGE_SZ - 1);

    typedef struct {
        logic [1:0]  st;
        logic [31:0] val;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [31:0] address;
    logic [31:0] length;
    logic        fixed_place;
    logic        sharing_given;
    logic        done;
    logic [1:0]  status;
    logic [31:0] value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the block's registers and tables
    logic [31:0] m_heap_floor, m_win_base, m_win_top, m_heap_start, m_heap_limit;
    logic        m_valid [MAPS];
    logic [31:0] m_base [MAPS];
    logic [31:0] m_len [MAPS];
    logic [31:0] m_break;
    logic        m_running;

    outcome_t    pending_q[$];
    int          err_count;
    bit          idle_on;

    page_region_allocator #(.MAX_MAPPINGS(MAPS), .PAGE_BYTES(PAGE_SZ)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .address(address), .length(length),
        .fixed_place(fixed_place), .sharing_given(sharing_given),
        .done(done), .status(status), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #25ms;
        $display("page_region_allocator verification failed");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [31:0] page_up(input logic [31:0] len);
        return (len + PMASK) & ~PMASK;
    endfunction

    function automatic bit ranges_overlap(input logic [63:0] a, la, b, lb);
        return (a < b + lb) && (b < a + la);
    endfunction

    function automatic bit range_taken(input logic [63:0] a, la, input bit with_heap,
                                       output logic [63:0] lo);
        lo = '0;
        for (int i = 0; i < MAPS; i++)
        begin
            if (m_valid[i] && ranges_overlap(a, la, m_base[i], m_len[i]))
            begin
                lo = m_base[i];
                return 1'b1;
            end
        end
        if (with_heap && m_break > m_heap_floor &&
            ranges_overlap(a, la, m_heap_floor, 64'(m_break) - m_heap_floor))
        begin
            lo = m_heap_floor;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void place_mapping(input logic [31:0] addr, len, input bit fx, sh,
                                          output logic [1:0] st, output logic [31:0] val);
        logic [63:0] size, cand, lo, need, step;
        int          slot;
        slot = -1;
        size = page_up(len);
        val  = '0;
        st   = ST_INVAL;
        if (size == 0 || !sh)
            return;
        for (int i = MAPS - 1; i >= 0; i--)
            if (!m_valid[i])
                slot = i;
        st = ST_NOSPC;
        if (slot < 0)
            return;
        if (fx)
        begin
            cand = addr & ~PMASK;
            st   = ST_INVAL;
            if (cand < m_win_base || cand + size > m_win_top ||
                range_taken(cand, size, 1'b1, lo))
                return;
        end
        else
        begin
            if (size > m_win_top)
                return;
            cand = 64'(m_win_top) - size;
            forever
            begin
                if (cand < m_win_base)
                    return;
                if (!range_taken(cand, size, 1'b1, lo))
                    break;
                // jump below the range that blocked this candidate
                need = cand + size - lo;
                step = ((need + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
                if (step > cand)
                    return;
                cand -= step;
            end
        end
        m_valid[slot] = 1'b1;
        m_base[slot]  = cand[31:0];
        m_len[slot]   = size[31:0];
        st  = ST_OK;
        val = cand[31:0];
    endfunction

    function automatic logic [31:0] move_break(input logic [31:0] req);
        logic [63:0] lo;
        if (!m_running && m_break == 0)
            return '0;
        if (req == 0 || req < m_heap_start || req >= m_heap_limit)
            return m_break;
        if (req > m_break && range_taken(m_break, 64'(req) - m_break, 1'b0, lo))
            return m_break;
        m_break = req;
        return m_break;
    endfunction

    function automatic outcome_t predict_outcome(input logic [2:0] op,
                                                 input logic [31:0] addr, len,
                                                 input bit fx, sh);
        outcome_t o;
        o.st  = ST_OK;
        o.val = '0;
        case (op)
            OP_MAP:
                place_mapping(addr, len, fx, sh, o.st, o.val);
            OP_UNMAP:
            begin
                o.st = ST_INVAL;
                for (int i = 0; i < MAPS; i++)
                begin
                    if (o.st != ST_OK && m_valid[i] && m_base[i] == addr &&
                        m_len[i] == page_up(len))
                    begin
                        m_valid[i] = 1'b0;
                        o.st = ST_OK;
                    end
                end
            end
            OP_BRK:
                o.val = move_break(addr);
            OP_START:
            begin
                for (int i = 0; i < MAPS; i++)
                    m_valid[i] = 1'b0;
                m_break   = m_heap_start;
                m_running = 1'b1;
                o.val     = m_break;
            end
            OP_END:
            begin
                m_running = 1'b0;
                o.val     = m_break;
            end
            default:
                o.st = ST_INVAL;
        endcase
        return o;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d value %h", status, value);
                err_count++;
            end
            else
            begin
                exp_o = pending_q.pop_front();
                if (status !== exp_o.st)
                begin
                    $error("status: expected %0d, got %0d", exp_o.st, status);
                    err_count++;
                end
                if (value !== exp_o.val)
                begin
                    $error("value: expected %h, got %h", exp_o.val, value);
                    err_count++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_cmd(input logic [2:0] op, input logic [31:0] addr, len,
                            input bit fx, input bit sh);
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        start         = 1'b1;
        operation     = op;
        address       = addr;
        length        = len;
        fixed_place   = fx;
        sharing_given = sh;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_q.push_back(predict_outcome(op, addr, len, fx, sh));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_HEAP_FLOOR:  m_heap_floor = data;
            REG_WINDOW_BASE: m_win_base   = data;
            REG_WINDOW_TOP:  m_win_top    = data;
            REG_HEAP_START:  m_heap_start = data;
            REG_HEAP_LIMIT:  m_heap_limit = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_layout(input logic [31:0] ub, wb, wt, hs, hl);
        drain();
        write_reg(REG_HEAP_FLOOR, ub);
        write_reg(REG_WINDOW_BASE, wb);
        write_reg(REG_WINDOW_TOP, wt);
        write_reg(REG_HEAP_START, hs);
        write_reg(REG_HEAP_LIMIT, hl);
    endtask

    // ---------------- directed tests ----------------
    task automatic test_idle_break;
        send_cmd(OP_BRK, 32'h0050_0000, '0, 0, 0);
        send_cmd(OP_END, '0, '0, 0, 0);
        send_cmd(OP_BRK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    endtask

    task automatic test_map_unmap;
        send_cmd(OP_START, '0, '0, 0, 0);
        send_cmd(OP_MAP, '0, 32'd1, 0, 1);
        send_cmd(OP_MAP, '0, 32'd4096, 0, 1);
        send_cmd(OP_MAP, 32'hFFFF_FFFF, 32'd4097, 0, 1);
        send_cmd(OP_MAP, '0, '0, 0, 1);                   // zero length
        send_cmd(OP_MAP, '0, 32'hFFFF_FFFF, 0, 1);        // rounds to zero
        send_cmd(OP_MAP, '0, 32'd4096, 0, 0);             // no sharing mode
        send_cmd(OP_MAP, 32'h2000_0123, 32'h3000, 1, 1);  // fixed, unaligned
        send_cmd(OP_MAP, 32'h1FFF_F000, 32'h1000, 1, 1);  // below window
        send_cmd(OP_MAP, 32'h2FFF_F000, 32'h2000, 1, 1);  // past window top
        send_cmd(OP_MAP, 32'h2FFF_E000, 32'h1000, 1, 1);  // overlaps a mapping
        send_cmd(OP_UNMAP, 32'h2FFF_F000, 32'd5, 0, 0);
        send_cmd(OP_UNMAP, 32'h2FFF_D000, 32'h1000, 0, 0); // address inside a mapping, not its base
        send_cmd(OP_UNMAP, 32'h2000_0000, 32'h3000, 0, 0);
    endtask

    task automatic test_break_moves;
        send_cmd(OP_BRK, '0, '0, 0, 0);
        send_cmd(OP_BRK, 32'h0050_0000, '0, 0, 0);
        send_cmd(OP_BRK, 32'h0048_0000, '0, 0, 0);
        send_cmd(OP_BRK, 32'h003F_F000, '0, 0, 0);
        send_cmd(OP_BRK, 32'h2000_0000, '0, 0, 0);
        send_cmd(OP_END, '0, '0, 0, 0);
        send_cmd(OP_BRK, 32'h0060_0000, '0, 0, 0);
    endtask

    task automatic test_table_full;
        send_cmd(OP_START, '0, '0, 0, 0);
        for (int i = 0; i <= MAPS; i++)
            send_cmd(OP_MAP, '0, 32'h2000, 0, 1);
        for (int op = OP_END + 1; op < 8; op++)
            send_cmd(op[2:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    endtask

    task automatic test_extreme_layout;
        set_layout('0, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
        for (int idx = REG_HEAP_LIMIT + 1; idx < 8; idx++)
            write_reg(idx[2:0], 32'hDEAD_BEEF);
        send_cmd(OP_START, '0, '0, 0, 0);
        send_cmd(OP_MAP, '0, 32'hFFFF_E001, 0, 1);
        send_cmd(OP_MAP, '0, '0, 0, 1);
        send_cmd(OP_BRK, 32'h0000_1000, '0, 0, 0);
        send_cmd(OP_BRK, 32'hFFFF_FFFE, '0, 0, 0);        // grows into the mapping
        send_cmd(OP_MAP, 32'h0000_0FFF, 32'h1000, 1, 1);  // fixed onto the mapping
        set_layout(32'h0040_0000, 32'h1000, '0, 32'h0040_0000, 32'h2000_0000);
        send_cmd(OP_MAP, '0, 32'h1000, 0, 1);             // bigger than the window top
    endtask

    // ---------------- random phase ----------------
    task automatic test_random(input int count);
        logic [2:0]  op;
        logic [31:0] addr, len, span;
        bit          fx, sh;
        int          r, live[$];
        for (int n = 0; n < count; n++)
        begin
            live.delete();
            for (int i = 0; i < MAPS; i++)
                if (m_valid[i])
                    live.push_back(i);
            span = (m_win_top > m_win_base) ? (m_win_top - m_win_base) / PAGE_SZ : 0;
            r    = $urandom_range(0, 99);
            addr = $urandom;
            len  = $urandom;
            fx   = $urandom_range(0, 1);
            sh   = $urandom_range(0, 1);
            if (r < 40)
            begin
                op   = OP_MAP;
                len  = (($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                   : $urandom_range(1, 6)) * PAGE_SZ;
                len  = len - $urandom_range(0, PAGE_SZ - 1);
                fx   = ($urandom_range(0, 2) == 0);
                sh   = ($urandom_range(0, 19) != 0);
                if (fx && live.size() != 0 && $urandom_range(0, 1))
                    addr = m_base[live[$urandom_range(0, live.size() - 1)]]
                           + ($urandom_range(0, 8) - 4) * PAGE_SZ + $urandom_range(0, 4095);
                else if (fx && $urandom_range(0, 3) != 0)
                    addr = m_win_base + $urandom_range(0, span) * PAGE_SZ
                           + $urandom_range(0, 4095);
            end
            else if (r < 70)
            begin
                op = OP_UNMAP;
                if (live.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    r    = live[$urandom_range(0, live.size() - 1)];
                    addr = m_base[r];
                    len  = m_len[r] - $urandom_range(0, PAGE_SZ - 1);
                    if ($urandom_range(0, 9) == 0)
                        len = len + PAGE_SZ;
                end
            end
            else if (r < 88)
            begin
                op = OP_BRK;
                if ($urandom_range(0, 5) == 0)
                    addr = '0;
                else if ($urandom_range(0, 1))
                    addr = m_heap_start + $urandom_range(0, 64) * PAGE_SZ + $urandom_range(0, 15);
                else
                    addr = m_break + ($urandom_range(0, 16) - 8) * PAGE_SZ;
            end
            else if (r < 91)
                op = OP_START;
            else if (r < 93)
                op = OP_END;
            else
                op = $urandom_range(0, 7);        // unconstrained noise
            send_cmd(op, addr, len, fx, sh);
        end
    endtask

    initial
    begin
        err_count     = 0;
        idle_on       = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = OP_MAP;
        address       = '0;
        length        = '0;
        fixed_place   = 1'b0;
        sharing_given = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_HEAP_FLOOR;
        cfg_data      = '0;
        m_heap_floor  = 32'h0040_0000;
        m_win_base    = 32'h2000_0000;
        m_win_top     = 32'h3000_0000;
        m_heap_start  = 32'h0040_0000;
        m_heap_limit  = 32'h2000_0000;
        m_break       = '0;
        m_running     = 1'b0;
        for (int i = 0; i < MAPS; i++)
        begin
            m_valid[i] = 1'b0;
            m_base[i]  = '0;
            m_len[i]   = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_break();
        test_map_unmap();
        test_break_moves();
        test_table_full();
        test_extreme_layout();

        set_layout(32'h0040_0000, 32'h2000_0000, 32'h3000_0000, 32'h0040_0000, 32'h2000_0000);
        send_cmd(OP_START, '0, '0, 0, 0);
        test_random(270);
        // heap sits inside the mapping window
        set_layout(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0005_0000);
        send_cmd(OP_START, '0, '0, 0, 0);
        test_random(270);
        // window top off a page boundary
        set_layout('0, 32'h0000_1000, 32'h003F_0123, 32'h0000_2000, 32'h0008_0000);
        send_cmd(OP_START, '0, '0, 0, 0);
        test_random(270);
        set_layout(32'h0000_0100, '0, 32'hFFFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF);
        send_cmd(OP_START, '0, '0, 0, 0);
        test_random(270);
        set_layout(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0005_0000);
        idle_on = 1'b0;
        send_cmd(OP_START, '0, '0, 0, 0);
        test_random(220);

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (err_count == 0)
            $display("page_region_allocator verification clean");
        else
            $display("page_region_allocator verification failed");
        $finish;
    end

endmodule
